// File: hw/rtl/sorted_insert_priority_queue_defines.svh
// Assertion macros used by the checker file.
// Both expect a signal named clock in the asserting scope; SIPQ_ASSERT also expects reset.
`ifndef SORTED_INSERT_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_INSERT_PRIORITY_QUEUE_DEFINES_SVH

// Checked only while out of reset.
`define SIPQ_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked at every edge, reset included.
`define SIPQ_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// File: hw/rtl/spq_pkg.sv
package spq_pkg;

   // Default number of queue cells
   localparam int unsigned DEPTH_DEFAULT = 16;

   // Command codes
   localparam logic CMD_ENQUEUE = 1'b0;
   localparam logic CMD_DEQUEUE = 1'b1;

   // Status codes
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   // Field widths
   localparam int unsigned PRIO_W   = 8;
   localparam int unsigned INFO_W   = 8;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned OCC_W    = 5;
   localparam int unsigned REQ_W    = 24;
   localparam int unsigned RSP_W    = 24;

   typedef struct packed {
      logic [PRIO_W-1:0] prio;
      logic [INFO_W-1:0] info;
   } entry_type;

   // Operation broadcast from the control to every cell
   typedef struct packed {
      logic      enq_go;
      logic      deq_go;
      entry_type new_entry;
   } op_type;

endpackage

// File: hw/rtl/spq_cell.sv
module spq_cell (
   input  logic               clock,
   input  spq_pkg::op_type    op,
   input  logic               occupied,
   input  logic               left_keep,
   input  spq_pkg::entry_type left_entry,
   input  spq_pkg::entry_type right_entry,
   output logic               keep,
   output spq_pkg::entry_type entry
);
   import spq_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;

   // Held entry stays in place when it is served no later than the new one
   assign keep = occupied && (entry_ff.prio <= op.new_entry.prio);

   // Hold, insert, shift right on enqueue; shift left on dequeue
   always_comb begin
      entry_in = entry_ff;
      if (op.enq_go) begin
         if (keep) begin
            entry_in = entry_ff;
         end else if (left_keep) begin
            entry_in = op.new_entry;
         end else begin
            entry_in = left_entry;
         end
      end else if (op.deq_go) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

// File: hw/rtl/sorted_insert_priority_queue.sv
// Channel  Direction  tdata fields (lowest bit first)
// req      in         cmd[0], new_priority[8:1], new_info[16:9], zero[23:17]
// rsp      out        out_priority[7:0], out_info[15:8], status[17:16],
//                     occupancy[22:18], zero[23]
//
// One transaction a cycle while responses are taken: every cell updates in the
// cycle of acceptance, each looking only at its own compare result and its neighbors.
// A response is registered and available the cycle after acceptance.
// The request side stays ready while the response register is empty or being taken.
// Reset (synchronous) empties the queue and drops any pending response.
module sorted_insert_priority_queue #(
   parameter int unsigned DEPTH = spq_pkg::DEPTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // cmd, new_priority, new_info, zero pad
   input  logic [spq_pkg::REQ_W-1:0]  req_tdata,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // out_priority, out_info, status, occupancy, zero pad
   output logic [spq_pkg::RSP_W-1:0]  rsp_tdata
);
   import spq_pkg::*;

   localparam int unsigned CW = $clog2(DEPTH + 1);

   logic            accept;
   logic            cmd;
   entry_type       new_entry;
   logic            full;
   logic            empty;
   op_type          op;
   logic [1:0]      status;
   entry_type       out_entry;

   logic [CW-1:0]   count_ff;
   logic [CW-1:0]   count_in;
   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   logic [RSP_W-1:0] rsp_data_ff;
   logic [RSP_W-1:0] rsp_data_in;

   entry_type       cell_entry [DEPTH];
   logic            cell_keep  [DEPTH];
   logic            cell_occ   [DEPTH];

   // Decode the request transaction
   assign accept         = req_tvalid && req_tready;
   assign cmd            = req_tdata[0];
   assign new_entry.prio = req_tdata[PRIO_W:1];
   assign new_entry.info = req_tdata[PRIO_W+INFO_W:PRIO_W+1];

   assign full  = (count_ff == CW'(DEPTH));
   assign empty = (count_ff == '0);

   assign op.enq_go    = accept && (cmd == CMD_ENQUEUE) && !full;
   assign op.deq_go    = accept && (cmd == CMD_DEQUEUE) && !empty;
   assign op.new_entry = new_entry;

   // Row of cells, front at index zero
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      entry_type left_e;
      entry_type right_e;
      logic      left_k;

      assign cell_occ[i] = (count_ff > CW'(i));

      if (i == 0) begin : g_first
         assign left_e = new_entry;
         assign left_k = 1'b1;
      end else begin : g_mid
         assign left_e = cell_entry[i-1];
         assign left_k = cell_keep[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_e = '0;
      end else begin : g_body
         assign right_e = cell_entry[i+1];
      end

      spq_cell u_cell (
         .clock      (clock),
         .op         (op),
         .occupied   (cell_occ[i]),
         .left_keep  (left_k),
         .left_entry (left_e),
         .right_entry(right_e),
         .keep       (cell_keep[i]),
         .entry      (cell_entry[i])
      );
   end

   // Advance the occupancy count
   always_comb begin
      count_in = count_ff;
      if (op.enq_go) begin
         count_in = count_ff + CW'(1);
      end else if (op.deq_go) begin
         count_in = count_ff - CW'(1);
      end
   end

   // Build the response
   always_comb begin
      status    = STATUS_OK;
      out_entry = '0;
      if (cmd == CMD_ENQUEUE) begin
         if (full) begin
            status = STATUS_FULL;
         end
      end else begin
         if (empty) begin
            status = STATUS_EMPTY;
         end else begin
            out_entry = cell_entry[0];
         end
      end
      rsp_data_in = {1'b0, OCC_W'(count_in), status, out_entry.info, out_entry.prio};
   end

   // Hold the response until it is taken
   assign req_tready   = !rsp_valid_ff || rsp_tready;
   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// File: hw/rtl/spq_checker.sv
`include "sorted_insert_priority_queue_defines.svh"

module spq_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_tvalid,
   input logic                      rsp_tready,
   input logic [spq_pkg::RSP_W-1:0] rsp_tdata
);
   import spq_pkg::*;

   logic [1:0]       st;
   logic [OCC_W-1:0] occ;

   assign st  = rsp_tdata[17:16];
   assign occ = rsp_tdata[22:18];

   // Drop any pending response on reset
   `SIPQ_ASSERT_ALWAYS(a_reset_clears_rsp, reset |=> !rsp_tvalid, "response valid after reset")

   // Hold a stalled response
   `SIPQ_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "stalled response changed")

   // Status is one of the defined codes
   `SIPQ_ASSERT(a_status_code, rsp_tvalid |-> (st == STATUS_OK || st == STATUS_EMPTY || st == STATUS_FULL), "undefined status")

   // A rejected command returns no entry
   `SIPQ_ASSERT(a_reject_zero, rsp_tvalid && st != STATUS_OK |-> rsp_tdata[15:0] == 16'h0, "entry on rejected command")

   // An empty status reports zero occupancy
   `SIPQ_ASSERT(a_empty_occ, rsp_tvalid && st == STATUS_EMPTY |-> occ == '0, "empty status with entries")

endmodule

bind sorted_insert_priority_queue spq_checker u_spq_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata)
);
